/* rtl/core/modbus_tcp_frame_parser_assert.svh */
// Assertion macros shared by the frame parser modules.
`ifndef MODBUS_TCP_FRAME_PARSER_ASSERT_SVH
`define MODBUS_TCP_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define MTFP_AST_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define MTFP_AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mtfp_pkg.sv */
// Types and constants of the Modbus TCP frame parser.
package mtfp_pkg;

	// One frame byte as it arrives.
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       end_of_frame;
	} frame_item_t;

	// One result record, data or summary.
	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [15:0] transaction_id;
		logic [7:0]  unit_id;
		logic [7:0]  function_code;
		logic [4:0]  description_code;
		logic [15:0] address;
		logic [15:0] quantity;
		logic [15:0] value;
		logic [7:0]  byte_count;
		logic [7:0]  exception_code;
		logic        last_of_run;
	} record_item_t;

	// Work handed from the front to the back: up to two records.
	typedef struct packed {
		logic         has_data;
		logic [7:0]   data_byte;
		logic         has_summary;
		record_item_t summary;
	} job_t;

	localparam int POS_W = 17;
	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_MAX     = '1;
	localparam pos_t POS_TID_HI  = 17'd0;
	localparam pos_t POS_TID_LO  = 17'd1;
	localparam pos_t POS_PROT_HI = 17'd2;
	localparam pos_t POS_PROT_LO = 17'd3;
	localparam pos_t POS_LEN_HI  = 17'd4;
	localparam pos_t POS_LEN_LO  = 17'd5;
	localparam pos_t POS_UNIT    = 17'd6;
	localparam pos_t POS_FUNC    = 17'd7;
	localparam pos_t POS_ADDR_HI = 17'd8;
	localparam pos_t POS_ADDR_LO = 17'd9;
	localparam pos_t POS_QTY_HI  = 17'd10;
	localparam pos_t POS_QTY_LO  = 17'd11;
	localparam pos_t POS_COUNT   = 17'd12;
	localparam pos_t POS_PAYLOAD = 17'd13;

	// Frame length limits, in bytes of the whole frame
	localparam pos_t N_HDR_MIN   = 17'd7;
	localparam pos_t N_PDU_START = 17'd8;
	localparam pos_t N_FIXED_MIN = N_PDU_START + 17'd4;
	localparam pos_t N_WM_BASE   = N_PDU_START + 17'd5;
	localparam pos_t N_EXC_MIN   = N_PDU_START + 17'd1;
	localparam pos_t LEN_ADJ     = 17'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_HDR_FAIL = 2'd1;
	localparam logic [1:0] ST_PDU_FAIL = 2'd2;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [7:0] FC_READ_FIRST  = 8'h01;
	localparam logic [7:0] FC_READ_LAST   = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
	localparam logic [7:0] FC_WRITE_REG   = 8'h06;
	localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
	localparam logic [7:0] FC_WRITE_REGS  = 8'h10;
	localparam logic [7:0] FC_EXC_FIRST   = 8'h80;
	localparam logic [7:0] FC_EXC_LAST    = 8'hFF;

	localparam logic [4:0] DESC_WRITE_COILS = 5'd6;
	localparam logic [4:0] DESC_WRITE_REGS  = 5'd7;
	localparam logic [4:0] DESC_EXC_BASE    = 5'd7;
	localparam logic [4:0] DESC_EXC_UNKNOWN = 5'd16;
	localparam logic [7:0] EXC_CODE_MIN     = 8'd1;
	localparam logic [7:0] EXC_CODE_MAX     = 8'h08;

	localparam logic [15:0] NONE16 = 16'hFFFF;

endpackage

/* rtl/core/mtfp_front.sv */
// Front end: byte capture, header and PDU classification, job generation.
`include "modbus_tcp_frame_parser_assert.svh"

module mtfp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	output logic                 frame_stall,
	input  mtfp_pkg::frame_item_t frame_item,
	output logic                 push,
	output mtfp_pkg::job_t       push_job,
	input  logic                 queue_full
);

	mtfp_pkg::pos_t pos_q, pos_next;
	logic [15:0] tid_q, prot_q, len_q, addr_q, qty_q;
	logic [15:0] tid_d, prot_d, len_d, addr_d, qty_d;
	logic [7:0]  unit_q, func_q, cnt_q, exc_q;
	logic [7:0]  unit_d, func_d, cnt_d, exc_d;
	logic        accept, has_data, wm_q, hdr_ok;
	logic [7:0]  b;
	mtfp_pkg::record_item_t summ;

	assign b           = frame_item.frame_byte;
	assign frame_stall = queue_full;
	assign accept      = frame_valid && !frame_stall;

	// field capture by byte position
	always_comb begin
		tid_d  = tid_q;
		prot_d = prot_q;
		len_d  = len_q;
		unit_d = unit_q;
		func_d = func_q;
		addr_d = addr_q;
		qty_d  = qty_q;
		cnt_d  = cnt_q;
		exc_d  = exc_q;
		unique case (pos_q)
			mtfp_pkg::POS_TID_HI:  tid_d  = {b, 8'h00};
			mtfp_pkg::POS_TID_LO:  tid_d  = {tid_q[15:8], b};
			mtfp_pkg::POS_PROT_HI: prot_d = {b, 8'h00};
			mtfp_pkg::POS_PROT_LO: prot_d = {prot_q[15:8], b};
			mtfp_pkg::POS_LEN_HI:  len_d  = {b, 8'h00};
			mtfp_pkg::POS_LEN_LO:  len_d  = {len_q[15:8], b};
			mtfp_pkg::POS_UNIT:    unit_d = b;
			mtfp_pkg::POS_FUNC:    func_d = b;
			mtfp_pkg::POS_ADDR_HI: begin
				addr_d = {b, 8'h00};
				exc_d  = b;
			end
			mtfp_pkg::POS_ADDR_LO: addr_d = {addr_q[15:8], b};
			mtfp_pkg::POS_QTY_HI:  qty_d  = {b, 8'h00};
			mtfp_pkg::POS_QTY_LO:  qty_d  = {qty_q[15:8], b};
			mtfp_pkg::POS_COUNT:   cnt_d  = b;
			default: ;
		endcase
	end

	assign pos_next = (pos_q == mtfp_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;

	// payload bytes of a write-multiple frame go out as they arrive
	assign wm_q = (func_q == mtfp_pkg::FC_WRITE_COILS) || (func_q == mtfp_pkg::FC_WRITE_REGS);
	assign has_data = (pos_q >= mtfp_pkg::POS_PAYLOAD) && wm_q
		&& (pos_q < mtfp_pkg::POS_PAYLOAD + mtfp_pkg::pos_t'(cnt_q));

	assign hdr_ok = (pos_next >= mtfp_pkg::N_HDR_MIN) && (prot_d == 16'h0000)
		&& (mtfp_pkg::pos_t'(len_d) + mtfp_pkg::LEN_ADJ == pos_next);

	// summary built from the fields including the current byte
	always_comb begin
		summ                = '0;
		summ.kind           = mtfp_pkg::KIND_SUMMARY;
		summ.last_of_run    = 1'b1;
		summ.status         = mtfp_pkg::ST_OK;
		summ.transaction_id = tid_d;
		summ.unit_id        = unit_d;
		summ.function_code  = func_d;
		summ.address        = mtfp_pkg::NONE16;
		summ.quantity       = mtfp_pkg::NONE16;
		if (!hdr_ok) begin
			summ.status = mtfp_pkg::ST_HDR_FAIL;
		end else if (pos_next < mtfp_pkg::N_PDU_START) begin
			summ.status = mtfp_pkg::ST_PDU_FAIL;
		end else begin
			unique case (func_d) inside
				[mtfp_pkg::FC_READ_FIRST:mtfp_pkg::FC_READ_LAST]: begin
					if (pos_next < mtfp_pkg::N_FIXED_MIN) begin
						summ.status = mtfp_pkg::ST_PDU_FAIL;
					end else begin
						summ.description_code = func_d[4:0] - 5'd1;
						summ.address          = addr_d;
						summ.quantity         = qty_d;
					end
				end
				mtfp_pkg::FC_WRITE_COIL, mtfp_pkg::FC_WRITE_REG: begin
					if (pos_next < mtfp_pkg::N_FIXED_MIN) begin
						summ.status = mtfp_pkg::ST_PDU_FAIL;
					end else begin
						summ.description_code = func_d[4:0] - 5'd1;
						summ.address          = addr_d;
						summ.value            = qty_d;
					end
				end
				mtfp_pkg::FC_WRITE_COILS, mtfp_pkg::FC_WRITE_REGS: begin
					if (pos_next < mtfp_pkg::N_WM_BASE + mtfp_pkg::pos_t'(cnt_d)) begin
						summ.status = mtfp_pkg::ST_PDU_FAIL;
					end else begin
						summ.description_code = (func_d == mtfp_pkg::FC_WRITE_COILS)
							? mtfp_pkg::DESC_WRITE_COILS : mtfp_pkg::DESC_WRITE_REGS;
						summ.address    = addr_d;
						summ.quantity   = qty_d;
						summ.byte_count = cnt_d;
					end
				end
				[mtfp_pkg::FC_EXC_FIRST:mtfp_pkg::FC_EXC_LAST]: begin
					if (pos_next < mtfp_pkg::N_EXC_MIN) begin
						summ.status = mtfp_pkg::ST_PDU_FAIL;
					end else begin
						summ.exception_code = exc_d;
						summ.description_code = (exc_d >= mtfp_pkg::EXC_CODE_MIN
							&& exc_d <= mtfp_pkg::EXC_CODE_MAX)
							? exc_d[4:0] + mtfp_pkg::DESC_EXC_BASE
							: mtfp_pkg::DESC_EXC_UNKNOWN;
					end
				end
				default: summ.status = mtfp_pkg::ST_PDU_FAIL;
			endcase
		end
	end

	assign push                 = accept && (has_data || frame_item.end_of_frame);
	assign push_job.has_data    = has_data;
	assign push_job.data_byte   = b;
	assign push_job.has_summary = frame_item.end_of_frame;
	assign push_job.summary     = summ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tid_q  <= '0;
			prot_q <= '0;
			len_q  <= '0;
			unit_q <= '0;
			func_q <= '0;
			addr_q <= '0;
			qty_q  <= '0;
			cnt_q  <= '0;
			exc_q  <= '0;
		end else if (accept) begin
			if (frame_item.end_of_frame) begin
				pos_q  <= '0;
				tid_q  <= '0;
				prot_q <= '0;
				len_q  <= '0;
				unit_q <= '0;
				func_q <= '0;
				addr_q <= '0;
				qty_q  <= '0;
				cnt_q  <= '0;
				exc_q  <= '0;
			end else begin
				pos_q  <= pos_next;
				tid_q  <= tid_d;
				prot_q <= prot_d;
				len_q  <= len_d;
				unit_q <= unit_d;
				func_q <= func_d;
				addr_q <= addr_d;
				qty_q  <= qty_d;
				cnt_q  <= cnt_d;
				exc_q  <= exc_d;
			end
		end
	end

	`MTFP_AST_NEXT(a_frame_restart, accept && frame_item.end_of_frame, pos_q == '0 && func_q == '0, "state not cleared after final byte")
	`MTFP_AST_NOW(a_push_room, push, !queue_full, "job pushed into a full queue")
	`MTFP_AST_NOW(a_data_needs_wm, push && push_job.has_data, wm_q && pos_q >= mtfp_pkg::POS_PAYLOAD, "data record outside write-multiple payload")

endmodule

/* rtl/core/mtfp_queue.sv */
// Short job queue between front and back ends.
`include "modbus_tcp_frame_parser_assert.svh"

module mtfp_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mtfp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output mtfp_pkg::job_t pop_job
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	mtfp_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	`MTFP_AST_NOW(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "queue count beyond depth")
	`MTFP_AST_NOW(a_no_underflow, pop, count_q != '0, "pop from an empty queue")
	`MTFP_AST_NEXT(a_count_step, push && !pop && !full, count_q == $past(count_q) + 1'b1, "count missed a push")

endmodule

/* rtl/core/mtfp_back.sv */
// Back end: unpacks jobs into records and holds the output item.
`include "modbus_tcp_frame_parser_assert.svh"

module mtfp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_valid,
	input  mtfp_pkg::job_t         job,
	output logic                   job_pop,
	output logic                   record_valid,
	input  logic                   record_stall,
	output mtfp_pkg::record_item_t record_item
);

	logic                   data_pend_q, sum_pend_q;
	logic [7:0]             data_byte_q;
	mtfp_pkg::record_item_t summary_q;
	logic                   accept, free;

	assign record_valid = data_pend_q || sum_pend_q;
	assign accept       = record_valid && !record_stall;
	// slot frees when empty, or when its only pending record leaves now
	assign free    = !record_valid || (accept && !(data_pend_q && sum_pend_q));
	assign job_pop = free && job_valid;

	// data record goes first when both are pending
	always_comb begin
		if (data_pend_q) begin
			record_item       = '0;
			record_item.kind  = mtfp_pkg::KIND_DATA;
			record_item.value = {8'h00, data_byte_q};
		end else begin
			record_item = summary_q;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			data_byte_q <= job.data_byte;
			summary_q   <= job.summary;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_pend_q <= 1'b0;
			sum_pend_q  <= 1'b0;
		end else if (job_pop) begin
			data_pend_q <= job.has_data;
			sum_pend_q  <= job.has_summary;
		end else if (accept) begin
			if (data_pend_q) begin
				data_pend_q <= 1'b0;
			end else begin
				sum_pend_q <= 1'b0;
			end
		end
	end

	`MTFP_AST_NEXT(a_summary_follows, accept && data_pend_q && sum_pend_q, record_valid && record_item.kind == mtfp_pkg::KIND_SUMMARY, "summary lost after data record")
	`MTFP_AST_NOW(a_last_on_summary, record_valid, (record_item.kind == mtfp_pkg::KIND_SUMMARY) == record_item.last_of_run, "last_of_run not on summary only")
	`MTFP_AST_NOW(a_job_not_empty, job_pop, job.has_data || job.has_summary, "empty job taken from queue")

endmodule

/* rtl/core/modbus_tcp_frame_parser.sv */
// Top level of the Modbus TCP frame parser.
// Usage
//  - frame channel (frame_valid / frame_stall / frame_item): one TCP payload byte per item,
//    end_of_frame set on the final byte. A byte is taken at an edge with valid high and
//    stall low. Stall rises only when the job queue is full.
//  - record channel (record_valid / record_stall / record_item): data records (kind 0)
//    for each write-multiple payload byte, then one summary record (kind 1,
//    last_of_run 1) per frame. A frame whose final byte is a payload byte gives the
//    data record first, the summary next.
//  - Throughput: one byte per cycle while frame_stall is low; header bytes produce no
//    record. A final byte that is also a payload byte gives its two records in turn.
//  - Path: a taken byte's job is first written into the queue, then loaded into the
//    output register of the back end, which shows the record until it is taken.
//  - Stalling the record side holds the shown record; bytes keep flowing until the
//    QUEUE_DEPTH job slots fill, then frame_stall rises.
//  - Reset (arst_n low) empties the queue, drops pending records and restarts
//    the byte count at the first header byte.
module modbus_tcp_frame_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   frame_valid,
	output logic                   frame_stall,
	input  mtfp_pkg::frame_item_t  frame_item,
	output logic                   record_valid,
	input  logic                   record_stall,
	output mtfp_pkg::record_item_t record_item
);

	// front to queue
	logic           push, queue_full;
	mtfp_pkg::job_t push_job;

	// queue to back
	logic           pop, pop_valid;
	mtfp_pkg::job_t pop_job;

	// Capture and classify; one job per byte that yields a record
	mtfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame_item  (frame_item),
		.push        (push),
		.push_job    (push_job),
		.queue_full  (queue_full)
	);

	// Decouples byte intake from output back-pressure
	mtfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_job   (pop_job)
	);

	// Output register; splits a job into its data and summary items
	mtfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (pop_valid),
		.job          (pop_job),
		.job_pop      (pop),
		.record_valid (record_valid),
		.record_stall (record_stall),
		.record_item  (record_item)
	);

endmodule
